[rtl/core/radio_frame_receiver_decoder_assert.svh]
// assertion macros for the radio frame receiver decoder checker
// needs a clk and an active-low rst_n in the scope that uses them
`ifndef RADIO_FRAME_RECEIVER_DECODER_ASSERT_SVH
`define RADIO_FRAME_RECEIVER_DECODER_ASSERT_SVH

// checked only while out of reset
`define RFRD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rfrd assertion failed");

// checked also during reset
`define RFRD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("rfrd assertion failed");

`endif

[rtl/core/rfrd_pkg.sv]
// shared types and constants of the radio frame receiver decoder
// no dependencies
package rfrd_pkg;

  // default depth of the frame store
  localparam int DEF_STORE_DEPTH = 8;

  // framing bytes
  localparam logic [7:0] BYTE_START  = 8'h4B;  // 'K'
  localparam logic [7:0] BYTE_END    = 8'h4F;  // 'O'
  localparam logic [7:0] BYTE_CHIRP  = 8'h7A;  // 'z'
  localparam logic [7:0] BYTE_HEADER = 8'h5E;  // '^'
  localparam logic [7:0] BYTE_HSHAKE = 8'h7E;  // '~'

  // high nibbles seen in a frame body
  localparam logic [3:0] NIB_IR      = 4'h2;
  localparam logic [3:0] NIB_DIGIT   = 4'h3;
  localparam logic [3:0] NIB_LETTER  = 4'h4;

  // offsets for ascii hex digits
  localparam logic [7:0] OFS_DIGIT   = 8'h30;
  localparam logic [7:0] OFS_LETTER  = 8'h37;

  typedef enum logic [1:0] {
    KIND_BAD_HEADER = 2'd0,
    KIND_HANDSHAKE  = 2'd1,
    KIND_DATA       = 2'd2,
    KIND_FULL       = 2'd3
  } frame_kind_t;

  // one decoded frame result
  typedef struct packed {
    frame_kind_t kind;
    logic        ir_updated;
    logic [3:0]  ir_first;
    logic [3:0]  ir_second;
    logic [3:0]  ir_third;
    logic [7:0]  chirp;
    logic [3:0]  instr;
  } res_t;

endpackage

[rtl/core/radio_frame_receiver_decoder.sv]
// radio frame receiver decoder: deframes received bytes and decodes frames
// depends on rfrd_pkg
//
//  channel | ports                          | moves
//  --------+--------------------------------+---------------------------------
//  input   | in_valid in_stall in_rx_byte   | one received byte per request
//  output  | out_valid out_stall out_*      | one decoded frame per 'O' byte
//
// one byte per cycle sustained while in_stall stays low; a byte passes through
// the input register, then is decoded into the two-entry result buffer
// the store and all held values are cleared by the synchronous reset
// in_stall rises only when an end byte waits and the result buffer is full
// other bytes keep flowing while results wait to be taken
module radio_frame_receiver_decoder
  import rfrd_pkg::*;
#(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_frame_kind,
  output logic       out_ir_updated,
  output logic [3:0] out_ir_first,
  output logic [3:0] out_ir_second,
  output logic [3:0] out_ir_third,
  output logic [7:0] out_chirp_strength,
  output logic [3:0] out_instruction_code
);

  localparam int WI_W  = $clog2(STORE_DEPTH + 1);
  localparam int IDX_W = $clog2(STORE_DEPTH);

  // value of one ascii hex digit as the decoder sees it
  function automatic logic [7:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    v = 8'd0;
    if (b[7:4] == NIB_DIGIT) begin
      v = b - OFS_DIGIT;
    end else if (b[7:4] == NIB_LETTER) begin
      v = b - OFS_LETTER;
    end
    return v;
  endfunction

  logic             in_full_r;
  logic [7:0]       byte_r;
  logic             capturing_r;
  logic [WI_W-1:0]  wi_r;
  logic [7:0]       store_r [STORE_DEPTH];
  logic [3:0]       ir_r [3];
  logic [7:0]       chirp_r;
  logic [3:0]       instr_r;
  logic             head_valid_r;
  res_t             head_r;
  logic             skid_valid_r;
  res_t             skid_r;

  logic             is_start;
  logic             is_end;
  logic             do_store;
  logic             proc_fire;
  logic             push;
  logic             pop;
  logic             in_take;

  logic             hdr_ok;
  logic             hshake;
  logic             body;
  logic             ir_hit;
  logic [7:0]       c0;
  logic [7:0]       c1;
  logic [7:0]       ins_b;
  logic [7:0]       hv0;
  logic             chirp_ok;
  logic [7:0]       chirp_nxt;
  res_t             res_nxt;

  // byte classification on the input register
  assign is_start  = (byte_r == BYTE_START);
  assign is_end    = (byte_r == BYTE_END);
  assign do_store  = !is_start && !is_end && (byte_r != BYTE_CHIRP) && capturing_r
                     && (wi_r < WI_W'(STORE_DEPTH));
  assign proc_fire = in_full_r && (!is_end || !skid_valid_r);
  assign push      = proc_fire && is_end;
  assign pop       = head_valid_r && !out_stall;
  assign in_stall  = in_full_r && !proc_fire;
  assign in_take   = in_valid && !in_stall;

  // fixed-position decode of the store
  always_comb begin
    hdr_ok   = (store_r[0] == BYTE_HEADER);
    hshake   = (store_r[1] == BYTE_HSHAKE);
    body     = hdr_ok && !hshake;
    ir_hit   = (store_r[1][7:4] == NIB_IR);
    c0       = ir_hit ? store_r[4] : store_r[1];
    c1       = ir_hit ? store_r[5] : store_r[2];
    ins_b    = ir_hit ? store_r[6] : store_r[3];
    chirp_ok = (c0[7:4] == NIB_DIGIT) || (c0[7:4] == NIB_LETTER);
    hv0      = hex_val(c0);
    chirp_nxt = chirp_ok ? ({hv0[3:0], 4'h0} | hex_val(c1)) : 8'd0;

    res_nxt.ir_updated = body && ir_hit;
    res_nxt.ir_first   = (body && ir_hit) ? store_r[1][3:0] : ir_r[0];
    res_nxt.ir_second  = (body && ir_hit) ? store_r[2][3:0] : ir_r[1];
    res_nxt.ir_third   = (body && ir_hit) ? store_r[3][3:0] : ir_r[2];
    res_nxt.chirp      = body ? chirp_nxt : chirp_r;
    res_nxt.instr      = (body && chirp_ok) ? ins_b[3:0] : instr_r;
    priority if (!hdr_ok) begin
      res_nxt.kind = KIND_BAD_HEADER;
    end else if (hshake) begin
      res_nxt.kind = KIND_HANDSHAKE;
    end else if (chirp_ok) begin
      res_nxt.kind = KIND_FULL;
    end else begin
      res_nxt.kind = KIND_DATA;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_take) begin
      in_full_r <= 1'b1;
    end else if (proc_fire) begin
      in_full_r <= 1'b0;
    end
    if (in_take) begin
      byte_r <= in_rx_byte;
    end
  end

  // capture control and frame store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capturing_r <= 1'b0;
      wi_r        <= '0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_r[i] <= 8'd0;
      end
    end else if (proc_fire) begin
      if (is_start) begin
        capturing_r <= 1'b1;
        wi_r        <= '0;
      end else if (is_end) begin
        capturing_r <= 1'b0;
      end else if (do_store) begin
        store_r[wi_r[IDX_W-1:0]] <= byte_r;
        wi_r                     <= wi_r + 1'b1;
      end
    end
  end

  // held decode values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_r[0] <= 4'd0;
      ir_r[1] <= 4'd0;
      ir_r[2] <= 4'd0;
      chirp_r <= 8'd0;
      instr_r <= 4'd0;
    end else if (push) begin
      ir_r[0] <= res_nxt.ir_first;
      ir_r[1] <= res_nxt.ir_second;
      ir_r[2] <= res_nxt.ir_third;
      chirp_r <= res_nxt.chirp;
      instr_r <= res_nxt.instr;
    end
  end

  // two-entry result buffer: head drives the ports, skid catches a result
  // while the head is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        head_r       <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (!head_valid_r || pop) begin
      head_valid_r <= push;
      if (push) begin
        head_r <= res_nxt;
      end
    end else if (push) begin
      skid_r       <= res_nxt;
      skid_valid_r <= 1'b1;
    end
  end

  assign out_valid            = head_valid_r;
  assign out_frame_kind       = head_r.kind;
  assign out_ir_updated       = head_r.ir_updated;
  assign out_ir_first         = head_r.ir_first;
  assign out_ir_second        = head_r.ir_second;
  assign out_ir_third         = head_r.ir_third;
  assign out_chirp_strength   = head_r.chirp;
  assign out_instruction_code = head_r.instr;

endmodule

[rtl/core/rfrd_checker.sv]
// port-level checker for the radio frame receiver decoder, with its bind
// depends on rfrd_pkg and radio_frame_receiver_decoder_assert.svh
`include "radio_frame_receiver_decoder_assert.svh"

module rfrd_checker
  import rfrd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_frame_kind,
  input logic       out_ir_updated,
  input logic [7:0] out_chirp_strength
);

  logic no_ir_kind;

  // kinds that stop before the frame body
  assign no_ir_kind = (out_frame_kind == KIND_BAD_HEADER) ||
                      (out_frame_kind == KIND_HANDSHAKE);

  // a stalled result stays and keeps its chirp value
  `RFRD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_chirp_strength))

  // no result may leave the reset
  `RFRD_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid)

  // bad header and handshake frames never load the ir values
  `RFRD_ASSERT(a_ir_kind, out_valid && no_ir_kind |-> !out_ir_updated)

  // a data frame without a chirp section clears the chirp strength
  `RFRD_ASSERT(a_chirp_clear, out_valid && out_frame_kind == KIND_DATA |-> out_chirp_strength == 8'd0)

endmodule

bind radio_frame_receiver_decoder rfrd_checker u_rfrd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_frame_kind     (out_frame_kind),
  .out_ir_updated     (out_ir_updated),
  .out_chirp_strength (out_chirp_strength)
);

[bench/rfrd_frame_checker.sv]
// checker for the radio frame receiver decoder: watches both channels,
// predicts each decoded frame and compares it field by field
// depends on rfrd_pkg
`timescale 1ns / 100ps

module rfrd_frame_checker
  import rfrd_pkg::*;
#(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_frame_kind,
  input  logic       out_ir_updated,
  input  logic [3:0] out_ir_first,
  input  logic [3:0] out_ir_second,
  input  logic [3:0] out_ir_third,
  input  logic [7:0] out_chirp_strength,
  input  logic [3:0] out_instruction_code,
  output int         mismatches,
  output int         pending,
  output int         bytes_taken,
  output int         frames_seen,
  output int         full_seen
);

  // shadow of the deframer and the held decode values
  logic       cap_on;
  logic [6:0] wr_idx;
  logic [7:0] store_img [STORE_DEPTH];
  logic [3:0] ir_img [3];
  logic [7:0] chirp_img;
  logic [3:0] instr_img;

  // decoded frames still owed by the block, oldest first
  res_t frames_due [$];

  int bad_cnt   = 0;
  int taken_cnt = 0;
  int seen_cnt  = 0;
  int full_cnt  = 0;

  initial begin
    mismatches  = 0;
    pending     = 0;
    bytes_taken = 0;
    frames_seen = 0;
    full_seen   = 0;
  end

  task automatic clear_shadow();
    cap_on    = 1'b0;
    wr_idx    = '0;
    chirp_img = '0;
    instr_img = '0;
    for (int k = 0; k < STORE_DEPTH; k++) store_img[k] = '0;
    for (int k = 0; k < 3; k++) ir_img[k] = '0;
  endtask

  // positions past the store read as zero
  function automatic logic [7:0] store_byte(input int pos);
    if (pos >= STORE_DEPTH) return 8'h00;
    return store_img[pos];
  endfunction

  // fixed-position decode of the store, updating the held values
  task automatic decode_store(output res_t r);
    int         p;
    logic [7:0] b;
    logic [3:0] hi;
    r = '0;
    r.kind = KIND_BAD_HEADER;
    if (store_byte(0) != BYTE_HEADER) begin
      r.kind = KIND_BAD_HEADER;
    end else if (store_byte(1) == BYTE_HSHAKE) begin
      r.kind = KIND_HANDSHAKE;
    end else begin
      p = 1;
      // ir section: three nibbles taken from bytes one to three
      b = store_byte(1);
      if (b[7:4] == NIB_IR) begin
        for (int k = 0; k < 3; k++) begin
          b = store_byte(1 + k);
          ir_img[k] = b[3:0];
        end
        r.ir_updated = 1'b1;
        p = 4;
      end
      chirp_img = '0;
      b = store_byte(p);
      hi = b[7:4];
      if (hi != NIB_DIGIT && hi != NIB_LETTER) begin
        r.kind = KIND_DATA;
      end else begin
        // two ascii hex digits, odd high nibbles add nothing
        for (int k = 0; k < 2; k++) begin
          b = store_byte(p + k);
          chirp_img = {chirp_img[3:0], 4'h0};
          if (b[7:4] == NIB_DIGIT) chirp_img = chirp_img | (b - OFS_DIGIT);
          else if (b[7:4] == NIB_LETTER) chirp_img = chirp_img | (b - OFS_LETTER);
        end
        b = store_byte(p + 2);
        instr_img = b[3:0];
        r.kind = KIND_FULL;
      end
    end
    r.ir_first  = ir_img[0];
    r.ir_second = ir_img[1];
    r.ir_third  = ir_img[2];
    r.chirp     = chirp_img;
    r.instr     = instr_img;
  endtask

  // one accepted byte request
  task automatic take_byte(input logic [7:0] b);
    res_t r;
    if (b == BYTE_START) begin
      wr_idx = '0;
      cap_on = 1'b1;
    end else if (b == BYTE_END) begin
      cap_on = 1'b0;
      decode_store(r);
      frames_due.push_back(r);
    end else if (b != BYTE_CHIRP && cap_on && wr_idx < STORE_DEPTH) begin
      store_img[wr_idx] = b;
      wr_idx = wr_idx + 7'd1;
    end
  endtask

  // compare one accepted frame result with the oldest prediction
  task automatic check_frame();
    res_t e;
    logic wrong;
    if (frames_due.size() == 0) begin
      bad_cnt++;
      if (bad_cnt <= 10)
        $display("unexpected frame result: kind=%0d upd=%0d ir=%h/%h/%h chirp=%h instr=%h",
                 out_frame_kind, out_ir_updated, out_ir_first, out_ir_second,
                 out_ir_third, out_chirp_strength, out_instruction_code);
    end else begin
      e = frames_due.pop_front();
      seen_cnt++;
      if (e.kind == KIND_FULL) full_cnt++;
      wrong = (out_frame_kind != e.kind) || (out_ir_updated != e.ir_updated) ||
              (out_ir_first != e.ir_first) || (out_ir_second != e.ir_second) ||
              (out_ir_third != e.ir_third) || (out_chirp_strength != e.chirp) ||
              (out_instruction_code != e.instr);
      if (wrong) begin
        bad_cnt++;
        if (bad_cnt <= 10) begin
          $display("frame %0d mismatch: exp kind=%0d upd=%0d ir=%h/%h/%h chirp=%h instr=%h",
                   seen_cnt, e.kind, e.ir_updated, e.ir_first, e.ir_second,
                   e.ir_third, e.chirp, e.instr);
          $display("              got kind=%0d upd=%0d ir=%h/%h/%h chirp=%h instr=%h",
                   out_frame_kind, out_ir_updated, out_ir_first, out_ir_second,
                   out_ir_third, out_chirp_strength, out_instruction_code);
        end
      end
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_shadow();
      frames_due.delete();
    end else begin
      if (out_valid && !out_stall) check_frame();
      if (in_valid && !in_stall) begin
        take_byte(in_rx_byte);
        taken_cnt++;
      end
    end
    mismatches  <= bad_cnt;
    pending     <= frames_due.size();
    bytes_taken <= taken_cnt;
    frames_seen <= seen_cnt;
    full_seen   <= full_cnt;
  end

endmodule

[bench/tb_radio_frame_receiver_decoder.sv]
// testbench top for the radio frame receiver decoder: drives byte requests
// and receiver stalls, gives the verdict
// depends on rfrd_pkg, radio_frame_receiver_decoder and rfrd_frame_checker
`timescale 1ns / 100ps

module tb_radio_frame_receiver_decoder;
  import rfrd_pkg::*;

  localparam int DEPTH       = DEF_STORE_DEPTH;
  localparam int RAND_ITEMS  = 950;
  localparam int CYCLE_LIMIT = 200000;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_stall  = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [1:0] out_frame_kind;
  logic       out_ir_updated;
  logic [3:0] out_ir_first;
  logic [3:0] out_ir_second;
  logic [3:0] out_ir_third;
  logic [7:0] out_chirp_strength;
  logic [3:0] out_instruction_code;

  int mismatches;
  int pending;
  int bytes_taken;
  int frames_seen;
  int full_seen;

  int idle_pct  = 0;
  int stall_pct = 0;
  int sent_cnt  = 0;
  int cycle_cnt = 0;

  // opening frames: end without start, handshake, full data without ir
  // and with a dropped chirp byte, short frame over a stale store, and a
  // full ir frame that overruns the store
  logic [7:0] opening [27];

  radio_frame_receiver_decoder #(.STORE_DEPTH(DEPTH)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_frame_kind      (out_frame_kind),
    .out_ir_updated      (out_ir_updated),
    .out_ir_first        (out_ir_first),
    .out_ir_second       (out_ir_second),
    .out_ir_third        (out_ir_third),
    .out_chirp_strength  (out_chirp_strength),
    .out_instruction_code(out_instruction_code)
  );

  rfrd_frame_checker #(.STORE_DEPTH(DEPTH)) u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_frame_kind      (out_frame_kind),
    .out_ir_updated      (out_ir_updated),
    .out_ir_first        (out_ir_first),
    .out_ir_second       (out_ir_second),
    .out_ir_third        (out_ir_third),
    .out_chirp_strength  (out_chirp_strength),
    .out_instruction_code(out_instruction_code),
    .mismatches          (mismatches),
    .pending             (pending),
    .bytes_taken         (bytes_taken),
    .frames_seen         (frames_seen),
    .full_seen           (full_seen)
  );

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d frames still owed", cycle_cnt, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stalls, changed at the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // one byte request: random gaps first, then hold until accepted
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_cnt++;
    @(negedge clk);
  endtask

  // any byte that is not a start, end or chirp byte
  function automatic logic [7:0] plain_byte();
    logic [7:0] v;
    do v = 8'($urandom); while (v == BYTE_START || v == BYTE_END || v == BYTE_CHIRP);
    return v;
  endfunction

  // ascii hex digit or letter, sometimes with an out-of-range low nibble
  function automatic logic [7:0] hex_char();
    logic [7:0] v;
    logic [3:0] lo;
    lo = 4'($urandom);
    case ($urandom_range(0, 4))
      0, 1: v = OFS_DIGIT + 8'($urandom_range(0, 9));
      2: v = 8'h41 + 8'($urandom_range(0, 5));
      3: v = {NIB_DIGIT, lo};
      default: begin
        do begin
          lo = 4'($urandom);
          v = {NIB_LETTER, lo};
        end while (v == BYTE_START || v == BYTE_END);
      end
    endcase
    return v;
  endfunction

  // random frame, mostly well formed, with chirp bytes, truncation and overrun
  task automatic send_frame();
    logic [7:0] body [$];
    int         choice;
    int         len;
    if ($urandom_range(0, 9) != 0) body.push_back(BYTE_HEADER);
    else body.push_back(plain_byte());
    choice = $urandom_range(0, 99);
    if (choice < 15) begin
      body.push_back(BYTE_HSHAKE);
    end else begin
      if (choice < 60) begin
        body.push_back({NIB_IR, 4'($urandom_range(0, 15))});
        repeat (2) begin
          if ($urandom_range(0, 99) < 85) body.push_back({NIB_IR, 4'($urandom_range(0, 15))});
          else body.push_back(plain_byte());
        end
      end
      if ($urandom_range(0, 4) != 0) begin
        body.push_back(hex_char());
        if ($urandom_range(0, 4) != 0) body.push_back(hex_char());
        else body.push_back(plain_byte());
        body.push_back(plain_byte());
      end else begin
        body.push_back(plain_byte());
      end
    end
    // shorten over a stale store, or run past the store depth
    choice = $urandom_range(0, 99);
    if (choice < 15) begin
      len = $urandom_range(0, body.size());
      while (body.size() > len) body.delete(body.size() - 1);
    end else if (choice < 27) begin
      len = DEPTH + $urandom_range(1, 3);
      while (body.size() < len) body.push_back(plain_byte());
    end
    if ($urandom_range(0, 19) != 0) send_byte(BYTE_START);
    for (int k = 0; k < body.size(); k++) begin
      if ($urandom_range(0, 9) == 0) send_byte(BYTE_CHIRP);
      send_byte(body[k]);
    end
    send_byte(BYTE_END);
  endtask

  // fully random bytes, framing bytes included
  task automatic send_noise();
    repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
  endtask

  // hold the sender off until every owed frame has come back
  task automatic drain_frames();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    opening = '{
      BYTE_END,
      BYTE_START, BYTE_HEADER, BYTE_HSHAKE, BYTE_END,
      BYTE_START, BYTE_HEADER, 8'h41, BYTE_CHIRP, 8'h30, 8'hFF, BYTE_END,
      BYTE_START, BYTE_HEADER, 8'h00, BYTE_END,
      BYTE_START, BYTE_HEADER, 8'h2A, 8'h25, 8'h2F, 8'h39, 8'h46, 8'h07,
      8'h00, 8'h80, BYTE_END
    };
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed frames with no idling
    for (int k = 0; k < 27; k++) send_byte(opening[k]);
    drain_frames();

    // random frames in four idle and stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 52; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 52; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      while (sent_cnt < (ph + 1) * RAND_ITEMS / 4) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        else send_frame();
      end
      drain_frames();
    end

    // let any late or stray result show up
    repeat (10) @(posedge clk);
    $display("covered %0d byte requests under four idle and stall mixes", bytes_taken);
    $display("checked %0d decoded frames, %0d of them with an instruction",
             frames_seen, full_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d frames still owed", mismatches, pending);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
